[sv/b64dt_pkg.sv]
// Shared types, character codes and lookup functions of the Base64 decoder
// with trailer check. Used by b64dt_step and base64_decode_with_trailer_unit.
// No dependencies.
`default_nettype none

package b64dt_pkg;

  localparam int COUNT_BITS = 24;
  localparam int COUNT_OUT_W = 24;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Group phase at the first pad character; selects the trailer text.
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sym_t;

  typedef struct packed {
    kind_t                    kind;
    logic [7:0]               data_byte;
    logic [COUNT_OUT_W-1:0]   byte_count;
  } result_t;

  typedef struct packed {
    logic [1:0] group_phase;
    logic       in_trailer;
  } step_status_t;

  function automatic sym_t sym_of(input logic [7:0] c);
    sym_t s;
    s.hit = 1'b1;
    s.value = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      s.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.value = 6'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.value = 6'(c + 8'h04);
    end else if (c == CH_PLUS) begin
      s.value = 6'd62;
    end else if (c == CH_SLASH) begin
      s.value = 6'd63;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [2:0] trailer_len(input logic [1:0] tkind);
    logic [2:0] len;
    case (tkind)
      PHASE_FIRST: len = 3'd4;
      PHASE_THIRD: len = 3'd7;
      default:     len = 3'd6;
    endcase
    return len;
  endfunction

  // Expected character at a trailer position: "===\n", "=\n====\n" or "\n====\n".
  function automatic logic [7:0] trailer_char(input logic [1:0] tkind,
                                              input logic [2:0] pos);
    logic [7:0] ch;
    case (tkind)
      PHASE_FIRST: ch = (pos == 3'd3) ? CH_LF : CH_EQ;
      PHASE_THIRD: ch = (pos == 3'd1 || pos == 3'd6) ? CH_LF : CH_EQ;
      default:     ch = (pos == 3'd0 || pos == 3'd5) ? CH_LF : CH_EQ;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[sv/b64dt_step.sv]
// Decoder state and the per-character step: symbol decode, byte assembly,
// trailer matching and the saturating byte count. Depends on b64dt_pkg.
`default_nettype none

module b64dt_step import b64dt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   char_in,
  output logic              has_result,
  output result_t           result,
  output step_status_t      status
);

  logic [1:0]            group_phase, group_phase_next;
  logic [7:0]            partial_bits, partial_bits_next;
  logic                  in_trailer, in_trailer_next;
  logic [2:0]            trailer_pos, trailer_pos_next;
  logic [1:0]            trailer_kind, trailer_kind_next;
  logic [COUNT_BITS-1:0] decoded_count, decoded_count_next;

  sym_t       sym;
  logic [2:0] tlen;
  logic [2:0] pos_inc;

  always_comb begin
    sym = sym_of(char_in);
    tlen = trailer_len(trailer_kind);
    pos_inc = trailer_pos + 3'd1;

    group_phase_next = group_phase;
    partial_bits_next = partial_bits;
    in_trailer_next = in_trailer;
    trailer_pos_next = trailer_pos;
    trailer_kind_next = trailer_kind;
    decoded_count_next = decoded_count;
    has_result = 1'b0;
    result.kind = KIND_ERR;
    result.data_byte = '0;
    result.byte_count = '0;

    if (in_trailer) begin
      if (trailer_pos >= tlen || char_in != trailer_char(trailer_kind, trailer_pos)) begin
        has_result = 1'b1;
      end else if (pos_inc == tlen) begin
        has_result = 1'b1;
        result.kind = KIND_DONE;
        result.byte_count = COUNT_OUT_W'(decoded_count);
      end else begin
        trailer_pos_next = pos_inc;
      end
    end else if (char_in == CH_LF) begin
      // Line breaks inside the data part are ignored.
    end else if (char_in == CH_EQ) begin
      if (group_phase == PHASE_SECOND) begin
        has_result = 1'b1;
      end else begin
        in_trailer_next = 1'b1;
        trailer_kind_next = group_phase;
        trailer_pos_next = '0;
      end
    end else if (!sym.hit) begin
      has_result = 1'b1;
    end else begin
      group_phase_next = group_phase + 2'd1;
      case (group_phase)
        2'd0: begin
          partial_bits_next = {sym.value, 2'b00};
        end
        2'd1: begin
          result.data_byte = partial_bits | {6'd0, sym.value[5:4]};
          partial_bits_next = {sym.value[3:0], 4'd0};
        end
        2'd2: begin
          result.data_byte = partial_bits | {4'd0, sym.value[5:2]};
          partial_bits_next = {sym.value[1:0], 6'd0};
        end
        default: begin
          result.data_byte = partial_bits | {2'd0, sym.value};
          partial_bits_next = '0;
        end
      endcase
      if (group_phase != 2'd0) begin
        has_result = 1'b1;
        result.kind = KIND_DATA;
        if (decoded_count != {COUNT_BITS{1'b1}}) begin
          decoded_count_next = decoded_count + COUNT_BITS'(1);
        end
      end
    end

    // Done and error both start a fresh message.
    if (has_result && result.kind != KIND_DATA) begin
      group_phase_next = '0;
      partial_bits_next = '0;
      in_trailer_next = 1'b0;
      trailer_pos_next = '0;
      trailer_kind_next = '0;
      decoded_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= '0;
      partial_bits <= '0;
      in_trailer <= 1'b0;
      trailer_pos <= '0;
      trailer_kind <= '0;
      decoded_count <= '0;
    end else if (step) begin
      group_phase <= group_phase_next;
      partial_bits <= partial_bits_next;
      in_trailer <= in_trailer_next;
      trailer_pos <= trailer_pos_next;
      trailer_kind <= trailer_kind_next;
      decoded_count <= decoded_count_next;
    end
  end

  assign status.group_phase = group_phase;
  assign status.in_trailer = in_trailer;

endmodule

`default_nettype wire

[sv/base64_decode_with_trailer_unit.sv]
// Top level of the Base64 decoder with trailer check: input register, the
// decode step and the result register. Depends on b64dt_pkg and b64dt_step.
//
// Usage:
//   Characters arrive one per beat on in_valid/in_ready/char_in. Each beat
//   gives zero or one result beat on out_valid/out_ready with kind,
//   data_byte and byte_count. A data byte comes for every symbol but the
//   first of each group of four; line breaks and the pad and trailer text
//   give nothing until the trailer completes (done, with the saturated byte
//   count) or a character is wrong (error). Either one starts a new message.
//   A character is held in the input register, decoded by the combinational
//   step and its result is written into the result register.
//   Throughput: one character per cycle while the result register is free
//   (out_ready high or no result waiting); a stalled receiver holds the flow.
//   Reset (rst, synchronous) clears the decoder state and the valid flags of both registers.
//   When the receiver stalls, one result waits in the output register and
//   one character in the input register; in_ready then falls.
`default_nettype none

module base64_decode_with_trailer_unit import b64dt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             char_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  kind,
  output logic [7:0]                  data_byte,
  output logic [COUNT_OUT_W-1:0]      byte_count
);

  logic         hold_valid;
  logic [7:0]   hold_char;
  logic         out_free;
  logic         advance;
  logic         step_has_result;
  result_t      step_result;
  step_status_t step_status;

  assign out_free = !out_valid || out_ready;
  assign advance = hold_valid && out_free;
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_char <= char_in;
    end
  end

  b64dt_step u_step (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .char_in    (hold_char),
    .has_result (step_has_result),
    .result     (step_result),
    .status     (step_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind <= step_result.kind;
      data_byte <= step_result.data_byte;
      byte_count <= step_result.byte_count;
    end
  end

  // Done and error results leave the decoder at the start of a new message.
  assert property (@(posedge clk) disable iff (rst)
    (advance && step_has_result && step_result.kind != KIND_DATA)
      |=> (step_status.group_phase == 2'd0 && !step_status.in_trailer))
    else $error("decoder state not cleared after done or error");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_DATA) |-> (data_byte == 8'd0))
    else $error("nonzero data byte on a done or error result");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_DONE) |-> (byte_count == '0))
    else $error("nonzero byte count outside a done result");

  // A data byte is never produced while the trailer is being matched.
  assert property (@(posedge clk) disable iff (rst)
    (advance && step_status.in_trailer && step_has_result)
      |-> (step_result.kind != KIND_DATA))
    else $error("data byte produced inside the trailer");

endmodule

`default_nettype wire
